// ===== hdl/bptc_pkg.sv =====
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types for the barometer temperature compensation pipeline:
// calibration set and the buses that pass between the pipeline sections.
// ----------------------------------------------------------------------------
package bptc_pkg;

   localparam int RawWidth  = 24;
   localparam int TempWidth = 21;
   localparam int PresWidth = 25;

   // register indexes on the csr port
   localparam logic [2:0] RegVariant  = 3'd0;
   localparam logic [2:0] RegPresSens = 3'd1;
   localparam logic [2:0] RegPresOff  = 3'd2;
   localparam logic [2:0] RegSensTc   = 3'd3;
   localparam logic [2:0] RegOffTc    = 3'd4;
   localparam logic [2:0] RegRefTemp  = 3'd5;
   localparam logic [2:0] RegTempSens = 3'd6;

   // calibration words and family select, as held in the register file
   typedef struct packed {
      logic        variant;
      logic [15:0] pres_sens;
      logic [15:0] pres_off;
      logic [15:0] sens_tc;
      logic [15:0] off_tc;
      logic [15:0] ref_temp;
      logic [15:0] temp_sens;
   } cal_type;

   // first-order results
   typedef struct packed {
      logic [RawWidth-1:0] d1;
      logic signed [18:0]  temp;
      logic signed [18:0]  d;     // temp - 2000
      logic signed [18:0]  c;     // temp + 1500
      logic signed [34:0]  off;
      logic signed [33:0]  sens;
      logic [47:0]         sq;    // dT squared
   } fo_type;

   // second-order corrected terms
   typedef struct packed {
      logic [RawWidth-1:0]        d1;
      logic signed [TempWidth-1:0] temp_out;
      logic signed [40:0]          s;     // SENS - SENSi
      logic signed [40:0]          o;     // OFF - OFFi
   } so_type;

endpackage

// ===== hdl/baro_pressure_temp_compensation_top.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top
// Second-order temperature compensation of raw barometer readings, with an
// APB register file for the calibration words.
//
//   channel  dir  payload
//   req      in   raw_pressure, raw_temperature
//   rsp      out  temperature_centi, pressure_scaled
//   csr      in   sensor_variant and six calibration words, 4-byte stride
//
// Ten register stages from req to rsp; one transaction per cycle sustained while rsp is not stalled.
// Latency is set by the multiplier stages: dT products, squares and the split
// D1 x SENS product each have a stage of their own.
// Every stage advances when its successor is empty or moving, so bubbles close
// up during an rsp stall and req keeps being taken until the pipe is full.
// Reset is synchronous: it empties the pipe and clears the calibration registers.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_top (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [20:0] temperature_centi, [45:21] pressure_scaled
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bptc_pkg::cal_type cal_ff;
   logic              wr_en;
   logic [2:0]        reg_idx;

   logic              fo_valid, fo_ready;
   bptc_pkg::fo_type  fo_data;
   logic              so_valid, so_ready;
   bptc_pkg::so_type  so_data;

   logic signed [bptc_pkg::TempWidth-1:0] temp_out;
   logic signed [bptc_pkg::PresWidth-1:0] pres_out;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            bptc_pkg::RegVariant:  cal_ff.variant   <= csr_pwdata[0];
            bptc_pkg::RegPresSens: cal_ff.pres_sens <= csr_pwdata[15:0];
            bptc_pkg::RegPresOff:  cal_ff.pres_off  <= csr_pwdata[15:0];
            bptc_pkg::RegSensTc:   cal_ff.sens_tc   <= csr_pwdata[15:0];
            bptc_pkg::RegOffTc:    cal_ff.off_tc    <= csr_pwdata[15:0];
            bptc_pkg::RegRefTemp:  cal_ff.ref_temp  <= csr_pwdata[15:0];
            bptc_pkg::RegTempSens: cal_ff.temp_sens <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         bptc_pkg::RegVariant:  csr_prdata = {31'd0, cal_ff.variant};
         bptc_pkg::RegPresSens: csr_prdata = {16'd0, cal_ff.pres_sens};
         bptc_pkg::RegPresOff:  csr_prdata = {16'd0, cal_ff.pres_off};
         bptc_pkg::RegSensTc:   csr_prdata = {16'd0, cal_ff.sens_tc};
         bptc_pkg::RegOffTc:    csr_prdata = {16'd0, cal_ff.off_tc};
         bptc_pkg::RegRefTemp:  csr_prdata = {16'd0, cal_ff.ref_temp};
         bptc_pkg::RegTempSens: csr_prdata = {16'd0, cal_ff.temp_sens};
         default:               csr_prdata = '0;
      endcase
   end

   bptc_first_order u_first_order (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_d1     (req_tdata[23:0]),
      .in_d2     (req_tdata[47:24]),
      .out_valid (fo_valid),
      .out_ready (fo_ready),
      .out_data  (fo_data)
   );

   bptc_second_order u_second_order (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal_ff),
      .in_valid  (fo_valid),
      .in_ready  (fo_ready),
      .in_data   (fo_data),
      .out_valid (so_valid),
      .out_ready (so_ready),
      .out_data  (so_data)
   );

   bptc_pressure u_pressure (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal_ff),
      .in_valid  (so_valid),
      .in_ready  (so_ready),
      .in_data   (so_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_temp  (temp_out),
      .out_pres  (pres_out)
   );

   assign rsp_tdata = {2'b00, pres_out, temp_out};

endmodule

// ===== hdl/bptc_first_order.sv =====
// ----------------------------------------------------------------------------
// bptc_first_order
// Three-stage first-order model: dT, the dT products, then TEMP, OFF and SENS
// with truncating shifts.
// ----------------------------------------------------------------------------
module bptc_first_order (
   input  logic                          clock,
   input  logic                          reset,
   input  bptc_pkg::cal_type             cal,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [bptc_pkg::RawWidth-1:0] in_d1,
   input  logic [bptc_pkg::RawWidth-1:0] in_d2,
   output logic                          out_valid,
   input  logic                          out_ready,
   output bptc_pkg::fo_type              out_data
);

   logic [2:0] vld_ff;
   logic [2:0] adv;

   // stage 1
   logic [bptc_pkg::RawWidth-1:0] d1_s1_ff;
   logic signed [24:0]            dt_in, dt_ff;
   // stage 2
   logic [bptc_pkg::RawWidth-1:0] d1_s2_ff;
   logic signed [41:0]            pt_in, pt_ff;
   logic signed [41:0]            po_in, po_ff;
   logic signed [41:0]            ps_in, ps_ff;
   logic signed [49:0]            sq_full;
   logic [47:0]                   sq_in, sq_ff;
   // stage 3
   logic signed [41:0]            pt_adj, po_adj, ps_adj;
   logic signed [41:0]            pt_q, po_q, ps_q;
   bptc_pkg::fo_type              fo_in, fo_ff;

   always_comb begin
      adv[2] = !vld_ff[2] || out_ready;
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[2];
   assign out_data  = fo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= in_valid;
         end
         if (adv[1]) begin
            vld_ff[1] <= vld_ff[0];
         end
         if (adv[2]) begin
            vld_ff[2] <= vld_ff[1];
         end
      end
   end

   assign dt_in = $signed({1'b0, in_d2}) - $signed({1'b0, cal.ref_temp, 8'h00});

   assign pt_in   = dt_ff * $signed({1'b0, cal.temp_sens});
   assign po_in   = dt_ff * $signed({1'b0, cal.off_tc});
   assign ps_in   = dt_ff * $signed({1'b0, cal.sens_tc});
   assign sq_full = dt_ff * dt_ff;
   assign sq_in   = sq_full[47:0];

   // divisions by powers of two round toward zero
   always_comb begin
      pt_adj = pt_ff[41] ? pt_ff + 42'sd8388607 : pt_ff;
      po_adj = po_ff[41] ? po_ff + 42'sd127 : po_ff;
      ps_adj = ps_ff[41] ? ps_ff + 42'sd255 : ps_ff;
      pt_q   = pt_adj >>> 23;
      po_q   = po_adj >>> 7;
      ps_q   = ps_adj >>> 8;

      fo_in.d1   = d1_s2_ff;
      fo_in.d    = $signed(pt_q[18:0]);
      fo_in.temp = $signed(pt_q[18:0]) + 19'sd2000;
      fo_in.c    = $signed(pt_q[18:0]) + 19'sd3500;
      fo_in.off  = $signed({3'b000, cal.pres_off, 16'h0000}) + $signed(po_q[34:0]);
      fo_in.sens = $signed({3'b000, cal.pres_sens, 15'h0000}) + $signed(ps_q[33:0]);
      fo_in.sq   = sq_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         d1_s1_ff <= in_d1;
         dt_ff    <= dt_in;
      end
      if (adv[1]) begin
         d1_s2_ff <= d1_s1_ff;
         pt_ff    <= pt_in;
         po_ff    <= po_in;
         ps_ff    <= ps_in;
         sq_ff    <= sq_in;
      end
      if (adv[2]) begin
         fo_ff <= fo_in;
      end
   end

endmodule

// ===== hdl/bptc_second_order.sv =====
// ----------------------------------------------------------------------------
// bptc_second_order
// Three-stage second-order correction: squares and Ti, then OFFi and SENSi,
// then the corrected OFF and SENS.
// ----------------------------------------------------------------------------
module bptc_second_order (
   input  logic              clock,
   input  logic              reset,
   input  bptc_pkg::cal_type cal,
   input  logic              in_valid,
   output logic              in_ready,
   input  bptc_pkg::fo_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output bptc_pkg::so_type  out_data
);

   logic [2:0] vld_ff;
   logic [2:0] adv;

   // stage 4
   logic signed [37:0]               dd_full, cc_full;
   logic [49:0]                      sq3;
   logic [16:0]                      ti;
   logic signed [bptc_pkg::TempWidth-1:0] temp_out_in, temp_s4_ff, temp_s5_ff;
   logic [35:0]                      dd_ff, cc_ff;
   logic                             cold_ff, frost_ff;
   logic signed [34:0]               off_s4_ff, off_s5_ff;
   logic signed [33:0]               sens_s4_ff, sens_s5_ff;
   logic [bptc_pkg::RawWidth-1:0]    d1_s4_ff, d1_s5_ff;
   // stage 5
   logic [39:0]                      dd40, cc40;
   logic [39:0]                      offi_in, sensi_in, offi_ff, sensi_ff;
   // stage 6
   bptc_pkg::so_type                 so_in, so_ff;

   always_comb begin
      adv[2] = !vld_ff[2] || out_ready;
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[2];
   assign out_data  = so_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= in_valid;
         end
         if (adv[1]) begin
            vld_ff[1] <= vld_ff[0];
         end
         if (adv[2]) begin
            vld_ff[2] <= vld_ff[1];
         end
      end
   end

   assign dd_full = in_data.d * in_data.d;
   assign cc_full = in_data.c * in_data.c;
   assign sq3     = {2'b00, in_data.sq} + {1'b0, in_data.sq, 1'b0};

   // Ti; below 2^17, so temp - Ti always stays inside the output field
   always_comb begin
      priority if (in_data.d[18]) begin
         ti = cal.variant ? sq3[49:33] : in_data.sq[47:31];
      end else if (cal.variant) begin
         ti = {5'b00000, in_data.sq[47:36]};
      end else begin
         ti = '0;
      end
      temp_out_in = $signed({{2{in_data.temp[18]}}, in_data.temp}) - $signed({4'b0000, ti});
   end

   always_comb begin
      dd40 = {4'b0000, dd_ff};
      cc40 = {4'b0000, cc_ff};
      priority if (cold_ff && !cal.variant) begin
         offi_in  = (((dd40 << 2) + dd40) >> 1)
                    + (frost_ff ? (cc40 << 3) - cc40 : 40'd0);
         sensi_in = (((dd40 << 2) + dd40) >> 2)
                    + (frost_ff ? (((cc40 << 3) + (cc40 << 1) + cc40) >> 1) : 40'd0);
      end else if (cold_ff) begin
         offi_in  = (((dd40 << 1) + dd40) >> 1)
                    + (frost_ff ? (cc40 << 3) - cc40 : 40'd0);
         sensi_in = (((dd40 << 2) + dd40) >> 3)
                    + (frost_ff ? (cc40 << 2) : 40'd0);
      end else if (cal.variant) begin
         offi_in  = dd40 >> 4;
         sensi_in = '0;
      end else begin
         offi_in  = '0;
         sensi_in = '0;
      end
   end

   always_comb begin
      so_in.d1       = d1_s5_ff;
      so_in.temp_out = temp_s5_ff;
      so_in.s        = $signed({{7{sens_s5_ff[33]}}, sens_s5_ff}) - $signed({1'b0, sensi_ff});
      so_in.o        = $signed({{6{off_s5_ff[34]}}, off_s5_ff}) - $signed({1'b0, offi_ff});
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dd_ff      <= dd_full[35:0];
         cc_ff      <= cc_full[35:0];
         cold_ff    <= in_data.d[18];
         frost_ff   <= in_data.c[18];
         temp_s4_ff <= temp_out_in;
         off_s4_ff  <= in_data.off;
         sens_s4_ff <= in_data.sens;
         d1_s4_ff   <= in_data.d1;
      end
      if (adv[1]) begin
         offi_ff    <= offi_in;
         sensi_ff   <= sensi_in;
         temp_s5_ff <= temp_s4_ff;
         off_s5_ff  <= off_s4_ff;
         sens_s5_ff <= sens_s4_ff;
         d1_s5_ff   <= d1_s4_ff;
      end
      if (adv[2]) begin
         so_ff <= so_in;
      end
   end

endmodule

// ===== hdl/bptc_pressure.sv =====
// ----------------------------------------------------------------------------
// bptc_pressure
// Four-stage pressure path: split D1 x SENS product, partial-product sum,
// scaling minus OFF, final scaling with saturation into the output register.
// ----------------------------------------------------------------------------
module bptc_pressure (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bptc_pkg::cal_type                     cal,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  bptc_pkg::so_type                      in_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [bptc_pkg::TempWidth-1:0] out_temp,
   output logic signed [bptc_pkg::PresWidth-1:0] out_pres
);

   localparam logic signed [45:0] PresMax = 46'sd16777215;
   localparam logic signed [45:0] PresMin = -46'sd16777216;

   logic [3:0] vld_ff;
   logic [3:0] adv;

   // stage 7
   logic [44:0]                           plo_in, plo_ff;
   logic signed [44:0]                    phi_in, phi_ff;
   logic signed [40:0]                    o_s7_ff, o_s8_ff;
   logic signed [bptc_pkg::TempWidth-1:0] temp_s7_ff, temp_s8_ff, temp_s9_ff, temp_ff;
   // stage 8
   logic signed [65:0]                    prod_in, prod_ff;
   // stage 9
   logic signed [65:0]                    prod_fl;
   logic                                  prod_rnd;
   logic signed [45:0]                    pr_in, pr_ff;
   // stage 10
   logic signed [45:0]                    pr_fl, pr_q;
   logic                                  pr_rnd;
   logic signed [bptc_pkg::PresWidth-1:0] pres_in, pres_ff;

   always_comb begin
      adv[3] = !vld_ff[3] || out_ready;
      adv[2] = !vld_ff[2] || adv[3];
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[3];
   assign out_temp  = temp_ff;
   assign out_pres  = pres_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= in_valid;
         end
         if (adv[1]) begin
            vld_ff[1] <= vld_ff[0];
         end
         if (adv[2]) begin
            vld_ff[2] <= vld_ff[1];
         end
         if (adv[3]) begin
            vld_ff[3] <= vld_ff[2];
         end
      end
   end

   // 41-bit SENS split into a 21-bit low half and a signed 20-bit high half
   assign plo_in = in_data.d1 * in_data.s[20:0];
   assign phi_in = $signed({1'b0, in_data.d1}) * $signed(in_data.s[40:21]);

   assign prod_in = $signed({phi_ff, 21'h000000}) + $signed({21'h000000, plo_ff});

   always_comb begin
      prod_fl  = prod_ff >>> 21;
      prod_rnd = prod_ff[65] && (|prod_ff[20:0]);
      pr_in    = $signed(prod_fl[45:0]) + $signed({45'd0, prod_rnd})
                 - $signed({{5{o_s8_ff[40]}}, o_s8_ff});
   end

   always_comb begin
      pr_fl  = cal.variant ? (pr_ff >>> 13) : (pr_ff >>> 15);
      pr_rnd = pr_ff[45] && (cal.variant ? (|pr_ff[12:0]) : (|pr_ff[14:0]));
      pr_q   = pr_fl + $signed({45'd0, pr_rnd});
      priority if (pr_q > PresMax) begin
         pres_in = PresMax[24:0];
      end else if (pr_q < PresMin) begin
         pres_in = PresMin[24:0];
      end else begin
         pres_in = pr_q[24:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         plo_ff     <= plo_in;
         phi_ff     <= phi_in;
         o_s7_ff    <= in_data.o;
         temp_s7_ff <= in_data.temp_out;
      end
      if (adv[1]) begin
         prod_ff    <= prod_in;
         o_s8_ff    <= o_s7_ff;
         temp_s8_ff <= temp_s7_ff;
      end
      if (adv[2]) begin
         pr_ff      <= pr_in;
         temp_s9_ff <= temp_s8_ff;
      end
      if (adv[3]) begin
         pres_ff <= pres_in;
         temp_ff <= temp_s9_ff;
      end
   end

endmodule
